@@ design/ebc_pkg.sv @@
`timescale 1ns / 1ps

package ebc_pkg;

  // Address and syndrome geometry
  localparam int ADDR_BITS = 27;
  localparam int BYTE_BITS = 29;
  localparam int SYN_BITS  = 7;
  localparam int IDX_BITS  = 5;
  localparam int ADJ_BITS  = 12;
  localparam logic [ADJ_BITS-1:0] ADJ_SKEW = 12'd5;
  localparam logic [SYN_BITS-1:0] SYN_CX   = 7'h01;

  localparam int DATA_SYNS  = 32;
  localparam int MULTI_SYNS = 25;

  typedef enum logic [1:0] {
    ACT_FATAL   = 2'd0,
    ACT_FIXUP   = 2'd1,
    ACT_DISCARD = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    CLS_NONE     = 3'd0,
    CLS_TIMEOUT  = 3'd1,
    CLS_OVERRUN  = 3'd2,
    CLS_SYNINVAL = 3'd3,
    CLS_SINGLE   = 3'd4,
    CLS_DOUBLE   = 3'd5,
    CLS_MULTIPLE = 3'd6
  } class_t;

  typedef enum logic [1:0] {
    BK_NONE  = 2'd0,
    BK_CX    = 2'd1,
    BK_CHECK = 2'd2,
    BK_DATA  = 2'd3
  } kind_t;

  // One captured bus error
  typedef struct packed {
    logic                 ear_valid;
    logic                 ear_ecc;
    logic                 ear_cpu;
    logic                 ear_write;
    logic [ADDR_BITS-1:0] ear_address;
    logic                 lo_valid;
    logic                 lo_single;
    logic [SYN_BITS-1:0]  lo_syndrome;
    logic                 hi_valid;
    logic                 hi_single;
    logic [SYN_BITS-1:0]  hi_syndrome;
    logic                 fixup_allowed;
  } capture_t;

  // Where the bad bit sits, from the syndrome alone
  typedef struct packed {
    logic                multi;
    kind_t               kind;
    logic [IDX_BITS-1:0] index;
  } locate_t;

  // One classification result
  typedef struct packed {
    action_t              action;
    logic [BYTE_BITS-1:0] byte_address;
    class_t               error_class;
    logic                 clear_capture;
    logic                 rewrite_word;
    kind_t                bit_kind;
    logic [IDX_BITS-1:0]  bit_index;
    logic [SYN_BITS-1:0]  syndrome_used;
  } result_t;

  // Syndrome of a single flipped data bit, indexed by bit number
  localparam logic [SYN_BITS-1:0] DATA_SYN [DATA_SYNS] = '{
    7'h4f, 7'h4a, 7'h52, 7'h54, 7'h57, 7'h58, 7'h5b, 7'h5d,
    7'h23, 7'h25, 7'h26, 7'h29, 7'h2a, 7'h2c, 7'h31, 7'h34,
    7'h0e, 7'h0b, 7'h13, 7'h15, 7'h16, 7'h19, 7'h1a, 7'h1c,
    7'h62, 7'h64, 7'h67, 7'h68, 7'h6b, 7'h6d, 7'h70, 7'h75
  };

  // Syndromes that only a multi-bit error produces
  localparam logic [SYN_BITS-1:0] MULTI_SYN [MULTI_SYNS] = '{
    7'h07, 7'h0d, 7'h1f, 7'h2f, 7'h32, 7'h37, 7'h38, 7'h3b, 7'h3d,
    7'h3e, 7'h43, 7'h45, 7'h46, 7'h49, 7'h4c, 7'h51, 7'h5e, 7'h61,
    7'h6e, 7'h73, 7'h76, 7'h79, 7'h7a, 7'h7c, 7'h7f
  };

  function automatic logic is_multi(input logic [SYN_BITS-1:0] syn);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < MULTI_SYNS; k++) begin
      hit = hit | (syn == MULTI_SYN[k]);
    end
    return hit;
  endfunction

endpackage

@@ design/ecc_bus_error_classifier.sv @@
`timescale 1ns / 1ps
// An accepted item passes through the input register, then the result register, to out_valid.
// One item per cycle unless out_ready stalls; only the decode lies between the two registers.
// A stalled result register holds its item while the input register still takes one more.
// Reset: synchronous, active low; clears both stage valid flags, payload is not reset.

module ecc_bus_error_classifier
  import ebc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_ear_valid,
  input  logic                 in_ear_ecc,
  input  logic                 in_ear_cpu,
  input  logic                 in_ear_write,
  input  logic [ADDR_BITS-1:0] in_ear_address,
  input  logic                 in_lo_valid,
  input  logic                 in_lo_single,
  input  logic [SYN_BITS-1:0]  in_lo_syndrome,
  input  logic                 in_hi_valid,
  input  logic                 in_hi_single,
  input  logic [SYN_BITS-1:0]  in_hi_syndrome,
  input  logic                 in_fixup_allowed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_action,
  output logic [BYTE_BITS-1:0] out_byte_address,
  output logic [2:0]           out_error_class,
  output logic                 out_clear_capture,
  output logic                 out_rewrite_word,
  output logic [1:0]           out_bit_kind,
  output logic [IDX_BITS-1:0]  out_bit_index,
  output logic [SYN_BITS-1:0]  out_syndrome_used
);

  capture_t cap_r;
  capture_t cap_nxt;
  logic     cap_vld_r;
  result_t  res_r;
  result_t  res_nxt;
  logic     res_vld_r;
  logic     res_free;
  logic     adv;
  logic     in_take;

  // Stage handshake
  assign res_free = !res_vld_r || out_ready;
  assign adv      = cap_vld_r && res_free;
  assign in_ready = !cap_vld_r || res_free;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    cap_nxt.ear_valid     = in_ear_valid;
    cap_nxt.ear_ecc       = in_ear_ecc;
    cap_nxt.ear_cpu       = in_ear_cpu;
    cap_nxt.ear_write     = in_ear_write;
    cap_nxt.ear_address   = in_ear_address;
    cap_nxt.lo_valid      = in_lo_valid;
    cap_nxt.lo_single     = in_lo_single;
    cap_nxt.lo_syndrome   = in_lo_syndrome;
    cap_nxt.hi_valid      = in_hi_valid;
    cap_nxt.hi_single     = in_hi_single;
    cap_nxt.hi_syndrome   = in_hi_syndrome;
    cap_nxt.fixup_allowed = in_fixup_allowed;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= 1'b0;
    end else if (in_ready) begin
      cap_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cap_r <= cap_nxt;
    end
  end

  ebc_decode u_decode (
    .cap (cap_r),
    .res (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_free) begin
      res_vld_r <= cap_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = res_vld_r;
  assign out_action        = res_r.action;
  assign out_byte_address  = res_r.byte_address;
  assign out_error_class   = res_r.error_class;
  assign out_clear_capture = res_r.clear_capture;
  assign out_rewrite_word  = res_r.rewrite_word;
  assign out_bit_kind      = res_r.bit_kind;
  assign out_bit_index     = res_r.bit_index;
  assign out_syndrome_used = res_r.syndrome_used;

`ifndef ASSERT_OFF
  // A single-bit error always scrubs and discards
  a_single_scrub: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_class == CLS_SINGLE) |->
      out_rewrite_word && (out_action == ACT_DISCARD))
    else $error("single error without scrub");

  // A rewrite only follows a cleared capture
  a_rewrite_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rewrite_word |-> out_clear_capture)
    else $error("rewrite without clear");

  // An invalid capture gives an all-zero result
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_clear_capture |->
      (out_action == ACT_FATAL) && (out_byte_address == '0) && (out_bit_kind == BK_NONE))
    else $error("invalid capture leaked fields");

  // Check bit CX only for syndrome one
  a_cx_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bit_kind == BK_CX) |->
      (out_bit_index == '0) && (out_syndrome_used == SYN_CX))
    else $error("bad CX location");

  // An item in the input register is held while the result side is blocked
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    cap_vld_r && !res_free |=> cap_vld_r && $stable(cap_r))
    else $error("input item lost under stall");
`endif

endmodule

@@ design/ebc_syn_locate.sv @@
`timescale 1ns / 1ps

module ebc_syn_locate
  import ebc_pkg::*;
(
  input  logic [SYN_BITS-1:0] syn,
  output locate_t             loc
);

  logic [DATA_SYNS-1:0] data_hit;
  logic [IDX_BITS-1:0]  data_idx;
  logic                 is_check;

  // Parallel compare against the data-bit table
  always_comb begin
    for (int k = 0; k < DATA_SYNS; k++) begin
      data_hit[k] = (syn == DATA_SYN[k]);
    end
  end

  // Table entries are distinct, so an OR of matching indices encodes the hit
  always_comb begin
    data_idx = '0;
    for (int k = 0; k < DATA_SYNS; k++) begin
      if (data_hit[k]) begin
        data_idx = data_idx | IDX_BITS'(k);
      end
    end
  end

  assign is_check = $onehot(syn);

  // Check bit first, then data bit, else unlocated
  always_comb begin
    loc.multi = is_multi(syn);
    if (is_check) begin
      loc.kind  = (syn == SYN_CX) ? BK_CX : BK_CHECK;
      loc.index = IDX_BITS'(syn >> 2);
    end else if (|data_hit) begin
      loc.kind  = BK_DATA;
      loc.index = data_idx;
    end else begin
      loc.kind  = BK_NONE;
      loc.index = '0;
    end
  end

endmodule

@@ design/ebc_decode.sv @@
`timescale 1ns / 1ps

module ebc_decode
  import ebc_pkg::*;
(
  input  capture_t cap,
  output result_t  res
);

  logic [ADDR_BITS-1:0] addr_adj;
  logic [ADJ_BITS-1:0]  low_adj;
  logic                 bank_hi;
  logic                 syn_valid;
  logic                 syn_single;
  logic [SYN_BITS-1:0]  syn;
  locate_t              loc;

  // ECC read errors: pull the low address bits back over the pipeline skew
  assign low_adj = cap.ear_address[ADJ_BITS-1:0] - ADJ_SKEW;

  always_comb begin
    addr_adj = cap.ear_address;
    if (cap.ear_ecc && !cap.ear_write) begin
      addr_adj[ADJ_BITS-1:0] = low_adj;
    end
  end

  // Bank select from the adjusted word address
  assign bank_hi    = addr_adj[0];
  assign syn_valid  = bank_hi ? cap.hi_valid    : cap.lo_valid;
  assign syn_single = bank_hi ? cap.hi_single   : cap.lo_single;
  assign syn        = bank_hi ? cap.hi_syndrome : cap.lo_syndrome;

  ebc_syn_locate u_locate (
    .syn (syn),
    .loc (loc)
  );

  // Classification
  always_comb begin
    res = '0;
    if (cap.ear_valid) begin
      res.clear_capture = 1'b1;
      res.byte_address  = BYTE_BITS'({addr_adj, 2'b00});
      res.action        = (cap.ear_cpu && cap.fixup_allowed) ? ACT_FIXUP : ACT_FATAL;
      if (!cap.ear_ecc) begin
        res.error_class = cap.ear_cpu ? CLS_TIMEOUT : CLS_OVERRUN;
      end else begin
        res.syndrome_used = syn;
        if (!syn_valid) begin
          res.error_class = CLS_SYNINVAL;
        end else begin
          if (loc.multi) begin
            res.error_class = CLS_MULTIPLE;
          end else if (!syn_single) begin
            res.error_class = CLS_DOUBLE;
          end else begin
            res.error_class  = CLS_SINGLE;
            res.rewrite_word = 1'b1;
            res.action       = ACT_DISCARD;
          end
          res.bit_kind  = loc.kind;
          res.bit_index = loc.index;
        end
      end
    end
  end

endmodule
